FILE: rtl/cwrc_pkg.sv
// Shared types, register map and arithmetic helpers of the coil winding run controller.
`default_nettype none

package cwrc_pkg;

	// Configuration register indexes (byte address is four times the index).
	localparam logic [2:0] REG_TARGET_TURNS   = 3'd0;
	localparam logic [2:0] REG_UNLIMITED_RUN  = 3'd1;
	localparam logic [2:0] REG_START_SPEED    = 3'd2;
	localparam logic [2:0] REG_WIND_DIRECTION = 3'd3;
	localparam logic [2:0] REG_HOLD_MS        = 3'd4;

	localparam int unsigned PADDR_W = 5;

	// Request codes.
	localparam logic REQ_START  = 1'b0;
	localparam logic REQ_SAMPLE = 1'b1;

	// Speed limits and turn limits.
	localparam logic [7:0]  SPEED_FLOOR = 8'd100;
	localparam logic [7:0]  SPEED_CEIL  = 8'd255;
	localparam int unsigned MAX_TURNS   = 16384;
	localparam int unsigned TURN_SAT    = 32767;
	localparam logic [14:0] TURN_LIMIT  = (MAX_TURNS > TURN_SAT) ? 15'(TURN_SAT)
	                                                             : 15'(MAX_TURNS);
	localparam logic [14:0] TURN_MAXCNT = 15'(TURN_SAT);

	// Reset values of the configuration registers.
	localparam logic [14:0] TARGET_TURNS_RST   = 15'd0;
	localparam logic        UNLIMITED_RUN_RST  = 1'b0;
	localparam logic [7:0]  START_SPEED_RST    = 8'd0;
	localparam logic        WIND_DIRECTION_RST = 1'b1;
	localparam logic [15:0] HOLD_MS_RST        = 16'd1000;

	// 2^24 * 100 / 155, rounded up; exact floor for distances up to 155.
	localparam logic [31:0] PCT_RECIP = 32'd10824011;

	typedef struct packed {
		logic        req_type;
		logic        enc_dt;
		logic        enc_clk;
		logic        hall_level;
		logic        button_level;
		logic [31:0] now_ms;
	} in_item_t;

	typedef struct packed {
		logic [7:0]        pwm_duty;
		logic signed [7:0] speed_percent;
		logic [14:0]       turn_count;
		logic              percent_changed;
		logic              turn_seen;
		logic              drive_fwd;
		logic              drive_rev;
		logic              run_done;
		logic              aborted;
	} out_item_t;

	// (spd - 100) * 100 / 155, truncated toward zero.
	function automatic logic signed [7:0] percent_of(input logic [7:0] spd);
		logic        above;
		logic [7:0]  mag;
		logic [31:0] prod;
		logic [7:0]  quo;
		above = (spd >= SPEED_FLOOR);
		mag   = above ? (spd - SPEED_FLOOR) : (SPEED_FLOOR - spd);
		prod  = {24'd0, mag} * PCT_RECIP;
		quo   = prod[31:24];
		return above ? $signed(quo) : $signed(8'd0 - quo);
	endfunction

endpackage

`default_nettype wire

FILE: rtl/coil_winding_run_controller_core.sv
// Top level of the coil winding run controller: register port, run state and result path.
//
// Usage: the input channel (in_valid, in_ready, in_data) carries start and sample
// transfers. A start transfer loads start_speed and clears the run state; each
// sample transfer carries encoder, hall and button levels and a millisecond stamp.
// Every input transfer yields exactly one result transfer on the output channel
// (out_valid, out_ready, out_data).
// Path: an accepted item is registered in stage one; its result is computed from
// stage one and stored in the output register, which offers it on the output
// channel. Throughput is one item per cycle while the receiver keeps out_ready
// high: the whole update is a short path from the stage-one register to the output
// register, limited by the speed step followed by one constant multiply.
// Stall: while the receiver holds out_ready low, the output register keeps its
// result, stage one still fills, and in_ready drops only when both are occupied.
// Reset: arst_n clears both stages, the run state (idle, run_done reported) and
// loads the register reset values. Registers are written through the APB-style
// port; the user must write them only while no transfer is in flight, which the
// block does not enforce; pready is always high.
`default_nettype none

module coil_winding_run_controller_core
	import cwrc_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	// Input channel.
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire in_item_t           in_data,
	// Output channel.
	output logic                    out_valid,
	input  wire logic               out_ready,
	output out_item_t               out_data,
	// Register port.
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [31:0]        pwdata,
	output logic [31:0]             prdata,
	output logic                    pready
);

	// Configuration registers.
	logic [14:0] target_turns_q;
	logic        unlimited_run_q;
	logic [7:0]  start_speed_q;
	logic        wind_direction_q;
	logic [15:0] hold_ms_q;

	// Run state.
	logic [7:0]        speed_q;
	logic              last_dt_q;
	logic              last_hall_q;
	logic              hall_known_q;
	logic signed [7:0] last_pct_q;
	logic [14:0]       turns_q;
	logic [31:0]       release_stamp_q;
	logic              release_seen_q;
	logic              running_q;
	logic              abort_q;

	// Pipeline and output registers.
	logic      valid_s1;
	in_item_t  item_s1;
	logic      out_valid_q;
	out_item_t out_data_q;

	logic [2:0] reg_idx;
	logic       reg_wr;
	logic       adv_s1;

	assign pready  = 1'b1;
	assign reg_idx = paddr[PADDR_W-1:2];
	assign reg_wr  = psel && penable && pwrite;

	// Register writes land in the access phase.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_turns_q   <= TARGET_TURNS_RST;
			unlimited_run_q  <= UNLIMITED_RUN_RST;
			start_speed_q    <= START_SPEED_RST;
			wind_direction_q <= WIND_DIRECTION_RST;
			hold_ms_q        <= HOLD_MS_RST;
		end else if (reg_wr) begin
			unique case (reg_idx)
				REG_TARGET_TURNS:   target_turns_q   <= pwdata[14:0];
				REG_UNLIMITED_RUN:  unlimited_run_q  <= pwdata[0];
				REG_START_SPEED:    start_speed_q    <= pwdata[7:0];
				REG_WIND_DIRECTION: wind_direction_q <= pwdata[0];
				REG_HOLD_MS:        hold_ms_q        <= pwdata[15:0];
				default:            ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_TARGET_TURNS:   prdata = {17'd0, target_turns_q};
			REG_UNLIMITED_RUN:  prdata = {31'd0, unlimited_run_q};
			REG_START_SPEED:    prdata = {24'd0, start_speed_q};
			REG_WIND_DIRECTION: prdata = {31'd0, wind_direction_q};
			REG_HOLD_MS:        prdata = {16'd0, hold_ms_q};
			default:            prdata = 32'd0;
		endcase
	end

	// Handshake: stage one moves on whenever the output register is free or
	// is being emptied in this cycle; the input side refills stage one then.
	assign adv_s1    = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || adv_s1;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_data;
		end
	end

	// Next state and result for the item in stage one.
	logic [7:0]        speed_n;
	logic              last_dt_n;
	logic              last_hall_n;
	logic              hall_known_n;
	logic signed [7:0] last_pct_n;
	logic [14:0]       turns_n;
	logic [31:0]       release_stamp_n;
	logic              release_seen_n;
	logic              running_n;
	logic              abort_n;
	out_item_t         res;

	logic [7:0]        spd_step;
	logic signed [7:0] pct;
	logic              seen;
	logic              hold_exceeded;
	logic              do_abort;
	logic              met;
	logic [31:0]       held_for;

	always_comb begin
		speed_n         = speed_q;
		last_dt_n       = last_dt_q;
		last_hall_n     = last_hall_q;
		hall_known_n    = hall_known_q;
		last_pct_n      = last_pct_q;
		turns_n         = turns_q;
		release_stamp_n = release_stamp_q;
		release_seen_n  = release_seen_q;
		running_n       = running_q;
		abort_n         = abort_q;

		// Encoder: a change on the data line is one detent; the clock line
		// level relative to the old data level gives the direction.
		spd_step = speed_q;
		if (item_s1.enc_dt != last_dt_q) begin
			if (item_s1.enc_clk != last_dt_q) begin
				if (speed_q < SPEED_CEIL) begin
					spd_step = speed_q + 8'd1;
				end
			end else if (speed_q > SPEED_FLOOR) begin
				spd_step = speed_q - 8'd1;
			end
		end

		pct  = percent_of(item_s1.req_type == REQ_START ? start_speed_q : spd_step);
		seen = !item_s1.hall_level && (!hall_known_q || last_hall_q);

		held_for      = item_s1.now_ms - release_stamp_q;
		hold_exceeded = held_for > {16'd0, hold_ms_q};
		do_abort      = !item_s1.button_level && release_seen_q && hold_exceeded;

		res = '0;

		if (item_s1.req_type == REQ_START) begin
			// Start or restart: fresh run, ends at once if the target is zero and the run is not unlimited.
			speed_n         = start_speed_q;
			last_dt_n       = 1'b0;
			last_hall_n     = 1'b0;
			hall_known_n    = 1'b0;
			last_pct_n      = '0;
			turns_n         = '0;
			release_stamp_n = '0;
			release_seen_n  = 1'b0;
			abort_n         = 1'b0;
			met             = !unlimited_run_q && (target_turns_q == 15'd0);
			running_n       = !met;
			res.pwm_duty      = 8'd0;
			res.speed_percent = pct;
			res.turn_count    = 15'd0;
		end else if (running_q) begin
			speed_n   = spd_step;
			last_dt_n = item_s1.enc_dt;
			if (seen && (turns_q < TURN_MAXCNT)) begin
				turns_n = turns_q + 15'd1;
			end
			last_hall_n  = item_s1.hall_level;
			hall_known_n = 1'b1;
			last_pct_n   = pct;
			if (item_s1.button_level) begin
				release_stamp_n = item_s1.now_ms;
				release_seen_n  = 1'b1;
			end
			if (do_abort) begin
				abort_n = 1'b1;
			end
			met = (turns_n >= TURN_LIMIT) ||
			      (!unlimited_run_q && (turns_n >= target_turns_q));
			running_n = !do_abort && !met;
			res.pwm_duty        = (running_n && (spd_step > SPEED_FLOOR)) ? spd_step : 8'd0;
			res.speed_percent   = pct;
			res.turn_count      = turns_n;
			res.percent_changed = (pct != last_pct_q);
			res.turn_seen       = seen;
		end else begin
			// Idle sample: report the last run, change nothing.
			met               = 1'b0;
			res.pwm_duty      = 8'd0;
			res.speed_percent = last_pct_q;
			res.turn_count    = turns_q;
		end

		res.drive_fwd = running_n && wind_direction_q;
		res.drive_rev = running_n && !wind_direction_q;
		res.run_done  = !running_n;
		res.aborted   = abort_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_q         <= '0;
			last_dt_q       <= 1'b0;
			last_hall_q     <= 1'b0;
			hall_known_q    <= 1'b0;
			last_pct_q      <= '0;
			turns_q         <= '0;
			release_stamp_q <= '0;
			release_seen_q  <= 1'b0;
			running_q       <= 1'b0;
			abort_q         <= 1'b0;
		end else if (adv_s1) begin
			speed_q         <= speed_n;
			last_dt_q       <= last_dt_n;
			last_hall_q     <= last_hall_n;
			hall_known_q    <= hall_known_n;
			last_pct_q      <= last_pct_n;
			turns_q         <= turns_n;
			release_stamp_q <= release_stamp_n;
			release_seen_q  <= release_seen_n;
			running_q       <= running_n;
			abort_q         <= abort_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			out_data_q <= res;
		end
	end

	// The two bridge lines are never driven together.
	a_drive_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(out_data_q.drive_fwd && out_data_q.drive_rev))
		else $error("both bridge lines active");

	// A finished run releases the motor enable.
	a_done_no_pwm: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_data_q.run_done |-> (out_data_q.pwm_duty == 8'd0))
		else $error("duty driven after run end");

	// An abort always ends the run it is reported with.
	a_abort_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_data_q.aborted |-> out_data_q.run_done)
		else $error("abort reported on a running result");

	// The run stops counting at the turn limit.
	a_turn_bound: assert property (@(posedge clk) disable iff (!arst_n)
		turns_q <= TURN_LIMIT)
		else $error("turn count beyond limit");

	// The run state only changes when a transfer moves through stage one.
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(adv_s1) && $past(arst_n) |-> $stable(running_q) && $stable(turns_q))
		else $error("run state changed without an item");

endmodule

`default_nettype wire
